// ===== hdl/mclsc_pkg.sv =====
// Package for the majority-clocked LFSR stream cipher.
// Holds the shift register state type, the control struct and the step and key load functions.
// Depends on nothing.
package mclsc_pkg;

    localparam int unsigned KeyWidth  = 64;
    localparam int unsigned ByteWidth = 8;
    localparam int unsigned StepCount = 8;

    localparam int unsigned ClkBitA = 9;
    localparam int unsigned ClkBitB = 11;
    localparam int unsigned ClkBitC = 11;

    typedef struct packed {
        logic [18:0] a;
        logic [21:0] b;
        logic [22:0] c;
    } t_lfsr_state;

    typedef struct packed {
        logic advance;
        logic load;
    } t_ks_ctrl;

    function automatic t_lfsr_state lfsr_step(input t_lfsr_state s);
        logic        ca;
        logic        cb;
        logic        cc;
        logic        maj;
        t_lfsr_state n;
        ca  = s.a[ClkBitA];
        cb  = s.b[ClkBitB];
        cc  = s.c[ClkBitC];
        maj = (ca & cb) | (ca & cc) | (cb & cc);
        n   = s;
        if (ca == maj) begin
            n.a = {s.a[17:0], s.a[18] ^ s.a[17] ^ s.a[16] ^ s.a[13]};
        end
        if (cb == maj) begin
            n.b = {s.b[20:0], s.b[21] ^ s.b[20] ^ s.b[16] ^ s.b[12]};
        end
        if (cc == maj) begin
            n.c = {s.c[21:0], s.c[22] ^ s.c[21] ^ s.c[18] ^ s.c[17]};
        end
        return n;
    endfunction

    // overlapping byte placement, first key byte in the top bits
    function automatic t_lfsr_state key_load(input logic [KeyWidth-1:0] key);
        logic [7:0]  k0;
        logic [7:0]  k1;
        logic [7:0]  k2;
        logic [7:0]  k3;
        logic [7:0]  k4;
        logic [7:0]  k5;
        logic [7:0]  k6;
        logic [7:0]  k7;
        t_lfsr_state n;
        k0  = key[63:56];
        k1  = key[55:48];
        k2  = key[47:40];
        k3  = key[39:32];
        k4  = key[31:24];
        k5  = key[23:16];
        k6  = key[15:8];
        k7  = key[7:0];
        n.a = {k0, k1, k2[7:5]};
        n.b = {k2[4:0], k3, 2'b00, k4[7:1]} | {21'd0, k5[7]};
        n.c = {k5, 15'd0} | {7'd0, k6, k7};
        return n;
    endfunction

endpackage

// ===== hdl/mclsc_ks.sv =====
// Keystream core: three shift registers and eight unrolled majority-clocked steps.
// Depends on mclsc_pkg.
module mclsc_ks (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mclsc_pkg::t_ks_ctrl           i_ctrl,
    input  logic [mclsc_pkg::KeyWidth-1:0] i_key,
    output logic [mclsc_pkg::ByteWidth-1:0] o_ks
);

    mclsc_pkg::t_lfsr_state r_state;
    mclsc_pkg::t_lfsr_state n_state;
    mclsc_pkg::t_lfsr_state w_after;
    logic [mclsc_pkg::ByteWidth-1:0] w_ks;

    always_comb begin
        mclsc_pkg::t_lfsr_state s;
        s    = r_state;
        w_ks = '0;
        for (int i = 0; i < mclsc_pkg::StepCount; i++) begin
            s = mclsc_pkg::lfsr_step(s);
            w_ks[mclsc_pkg::ByteWidth-1-i] = s.a[0] ^ s.b[0] ^ s.c[0];
        end
        w_after = s;
    end

    always_comb begin
        n_state = r_state;
        if (i_ctrl.advance) begin
            n_state = i_ctrl.load ? mclsc_pkg::key_load(i_key) : w_after;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ks = w_ks;

endmodule

// ===== hdl/majority_clocked_lfsr_stream_cipher_top.sv =====
// Top level of the majority-clocked LFSR stream cipher.
// Input word register, keystream core, result register and key register.
// Depends on mclsc_pkg and mclsc_ks.
//
//  channel  direction  signals                    payload
//  s_axis   in         tvalid tready tdata tuser  tdata: data_in; tuser: kind
//  m_axis   out        tvalid tready tdata        tdata: data_out
//  cfg      in         valid ready data           cipher_key
//
// One word per cycle while m_axis takes results; a word is held in the input
// register, and the eight steps resolve in logic before the result register.
// A load word (kind 0) yields no result and passes even while m_axis stalls.
// Reset clears the key, the shift registers and all valid flags.
// Key writes are always ready; the key takes effect at the next load word.
module majority_clocked_lfsr_stream_cipher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_in
    input  logic [0:0]  i_s_axis_tuser,   // [0] kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] data_out
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    logic        r_in_valid;
    logic        n_in_valid;
    logic        r_in_kind;
    logic [7:0]  r_in_data;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_out_data;
    logic [63:0] r_key;
    logic        w_in_accept;
    logic        w_out_free;
    logic        w_in_adv;
    logic [7:0]  w_ks;
    mclsc_pkg::t_ks_ctrl w_ctrl;

    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_in_adv        = r_in_valid && (!r_in_kind || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_in_adv;
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign w_ctrl.advance = w_in_adv;
    assign w_ctrl.load    = !r_in_kind;

    mclsc_ks u_ks (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_key   (r_key),
        .o_ks    (w_ks)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_in_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_in_adv && r_in_kind) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_key       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_key <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_kind <= i_s_axis_tuser[0];
            r_in_data <= i_s_axis_tdata;
        end
        if (w_in_adv && r_in_kind) begin
            r_out_data <= r_in_data ^ w_ks;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_kind && w_out_free) |=> !o_m_axis_tvalid)
        else $error("load word produced a result");

    a_data_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_kind && w_out_free) |=> o_m_axis_tvalid)
        else $error("data word lost");

    a_ready_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_in_kind && r_out_valid))
        else $error("input stalled without a blocked data word");

    a_hold_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_kind && !w_out_free) |=> (r_in_valid && $stable(r_in_data)))
        else $error("blocked data word dropped");
`endif

endmodule
